FILE: hw/rtl/bmm_pkg.sv
// Shared widths, stage count and configuration register indexes for the
// Barrett modular multiplier. No dependencies.
package bmm_pkg;

  localparam int unsigned CoeffW  = 30;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ProdW   = 2 * CoeffW;
  localparam int unsigned ProdHiW = ProdW - WordW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumStg  = 7;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS    = 2'd0,
    CFG_RATIO_LOW  = 2'd1,
    CFG_RATIO_HIGH = 2'd2
  } cfg_idx_t;

  localparam logic [CoeffW-1:0] ModulusRst   = 30'd2;
  localparam logic [WordW-1:0]  RatioLowRst  = 32'h0000_0000;
  localparam logic [WordW-1:0]  RatioHighRst = 32'h8000_0000;

endpackage

FILE: hw/rtl/bmm_quot.sv
// Quotient estimate stages of the Barrett multiplier: partial products of
// the product words with the ratio words, then carry resolution. Uses bmm_pkg.
module bmm_quot
  import bmm_pkg::*;
(
  input  logic               clk,
  input  logic [2:0]         ld,
  input  logic [WordW-1:0]   p0,
  input  logic [ProdHiW-1:0] p1,
  input  logic [WordW-1:0]   ratio_low,
  input  logic [WordW-1:0]   ratio_high,
  output logic [WordW-1:0]   quot
);

  logic [2*WordW-1:0]       t_full;
  logic [2*WordW-1:0]       m_full;
  logic [ProdHiW+WordW-1:0] n_full;
  logic [ProdHiW+WordW-1:0] w_full;

  logic [WordW-1:0]   t_hi_r, m_lo_r, m_hi_r, n_lo_r, w_lo_r;
  logic [ProdHiW-1:0] n_hi_r;
  logic [WordW:0]     mid_r;
  logic [WordW-1:0]   part_r, n_lo2_r;
  logic [WordW-1:0]   quot_r;

  logic [WordW:0]     mid_nxt;
  logic [WordW-1:0]   part_nxt;
  logic [WordW:0]     sum2;
  logic [WordW-1:0]   quot_nxt;

  // Four partial products of the product words with the ratio words.
  assign t_full = p0 * ratio_low;
  assign m_full = p0 * ratio_high;
  assign n_full = p1 * ratio_low;
  assign w_full = p1 * ratio_high;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      t_hi_r <= t_full[2*WordW-1:WordW];
      m_lo_r <= m_full[WordW-1:0];
      m_hi_r <= m_full[2*WordW-1:WordW];
      n_lo_r <= n_full[WordW-1:0];
      n_hi_r <= n_full[ProdHiW+WordW-1:WordW];
      w_lo_r <= w_full[WordW-1:0];
    end
  end

  // Middle word with its first carry, and the high words summed.
  assign mid_nxt  = {1'b0, t_hi_r} + {1'b0, m_lo_r};
  assign part_nxt = w_lo_r + m_hi_r + {{(WordW-ProdHiW){1'b0}}, n_hi_r};

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      mid_r   <= mid_nxt;
      part_r  <= part_nxt;
      n_lo2_r <= n_lo_r;
    end
  end

  // Second carry out of the middle word, then the estimate modulo 2^32.
  assign sum2     = {1'b0, mid_r[WordW-1:0]} + {1'b0, n_lo2_r};
  assign quot_nxt = part_r + {{(WordW-1){1'b0}}, mid_r[WordW]}
                  + {{(WordW-1){1'b0}}, sum2[WordW]};

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

FILE: hw/rtl/barrett_modular_multiplier.sv
// Throughput: one word per cycle; stages move independently, so bubbles
// close up while the output is stalled and in_stall rises only when every
// stage holds a word. Reset (synchronous, rst_n low) empties all stages and
// loads modulus 2, ratio_low 0 and ratio_high 0x80000000.
// Top level of the Barrett modular multiplier; uses bmm_pkg and bmm_quot.
module barrett_modular_multiplier
  import bmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CoeffW-1:0]   in_coeff_a,
  input  logic [CoeffW-1:0]   in_coeff_b,
  input  logic                in_last_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CoeffW-1:0]   out_residue,
  output logic                out_last_out,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [WordW-1:0]    cfg_wdata
);

  logic [CoeffW-1:0] modulus_r;
  logic [WordW-1:0]  ratio_low_r;
  logic [WordW-1:0]  ratio_high_r;

  logic [NumStg-1:0] vld_r;
  logic [NumStg-1:0] vld_nxt;
  logic [NumStg-1:0] rdy;
  logic [NumStg-1:0] last_r;

  logic [ProdW-1:0]      prod_r;
  logic [WordW-1:0]      p0_r [1:4];
  logic [WordW-1:0]      quot;
  logic [WordW+CoeffW-1:0] qm_full;
  logic [WordW-1:0]      qm_r;
  logic [WordW-1:0]      rem_r;
  logic [WordW-1:0]      rem_nxt;
  logic [WordW-1:0]      fix;
  logic [CoeffW-1:0]     res_r;
  logic [CoeffW-1:0]     res_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= ModulusRst;
      ratio_low_r  <= RatioLowRst;
      ratio_high_r <= RatioHighRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:    modulus_r    <= cfg_wdata[CoeffW-1:0];
        CFG_RATIO_LOW:  ratio_low_r  <= cfg_wdata;
        CFG_RATIO_HIGH: ratio_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its word moves on this cycle.
  always_comb begin
    rdy[NumStg-1] = !vld_r[NumStg-1] || !out_stall;
    for (int k = NumStg - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NumStg; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // The last mark travels alongside each word.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      last_r[0] <= in_last_in;
    end
    for (int k = 1; k < NumStg; k++) begin
      if (rdy[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // Stage 0: full coefficient product.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_r <= in_coeff_a * in_coeff_b;
    end
  end

  // Low product word delayed to meet q times the quotient estimate.
  always_ff @(posedge clk) begin
    if (rdy[1]) p0_r[1] <= prod_r[WordW-1:0];
    if (rdy[2]) p0_r[2] <= p0_r[1];
    if (rdy[3]) p0_r[3] <= p0_r[2];
    if (rdy[4]) p0_r[4] <= p0_r[3];
  end

  // Stages 1 to 3: quotient estimate.
  bmm_quot u_quot (
    .clk        (clk),
    .ld         (rdy[3:1]),
    .p0         (prod_r[WordW-1:0]),
    .p1         (prod_r[ProdW-1:WordW]),
    .ratio_low  (ratio_low_r),
    .ratio_high (ratio_high_r),
    .quot       (quot)
  );

  // Stage 4: q times the estimate, low word only.
  assign qm_full = quot * modulus_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      qm_r <= qm_full[WordW-1:0];
    end
  end

  // Stage 5: remainder modulo 2^32.
  assign rem_nxt = p0_r[4] - qm_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      rem_r <= rem_nxt;
    end
  end

  // Stage 6: one conditional subtraction of q.
  always_comb begin
    fix = rem_r;
    if (rem_r >= {{(WordW-CoeffW){1'b0}}, modulus_r}) begin
      fix = rem_r - {{(WordW-CoeffW){1'b0}}, modulus_r};
    end
    res_nxt = fix[CoeffW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      res_r <= res_nxt;
    end
  end

  assign in_stall     = !rdy[0];
  assign out_valid    = vld_r[NumStg-1];
  assign out_residue  = res_r;
  assign out_last_out = last_r[NumStg-1];

endmodule

FILE: hw/rtl/bmm_checker.sv
// Port-level checks for the Barrett modular multiplier, bound to its top
// level. Uses bmm_pkg for field widths.
module bmm_checker
  import bmm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CoeffW-1:0] out_residue,
  input logic              out_last_out
);

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_residue) && $stable(out_last_out))
    else $error("result word changed while stalled");

  // Back pressure on the input only arises from a stalled full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("word present right after reset");

endmodule

bind barrett_modular_multiplier bmm_checker u_bmm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_residue  (out_residue),
  .out_last_out (out_last_out)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Barrett modular multiplier: drives coefficient words
// with random gaps and stalls and compares each residue against a built-in Barrett model.
// Depends on bmm_pkg and barrett_modular_multiplier.
module tb_top;
  import bmm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [CoeffW-1:0]  CoeffMax  = {CoeffW{1'b1}};

  typedef struct packed {
    logic [CoeffW-1:0] residue;
    logic              last;
  } residue_word_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CoeffW-1:0] in_coeff_a = '0;
  logic [CoeffW-1:0] in_coeff_b = '0;
  logic              in_last_in = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CoeffW-1:0] out_residue;
  logic              out_last_out;
  logic              cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [WordW-1:0]  cfg_wdata = '0;

  // Register copies that the predictor works from.
  logic [CoeffW-1:0] cur_modulus  = ModulusRst;
  logic [WordW-1:0]  cur_ratio_lo = RatioLowRst;
  logic [WordW-1:0]  cur_ratio_hi = RatioHighRst;

  residue_word_t expected_residues[$];
  int unsigned   mismatch_count = 0;
  int unsigned   stall_left = 0;
  bit            no_idle = 1'b0;

  barrett_modular_multiplier DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_coeff_a   (in_coeff_a),
    .in_coeff_b   (in_coeff_b),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_residue  (out_residue),
    .out_last_out (out_last_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Barrett reduction of a*b with the current register copies, all arithmetic mod 2^32.
  function automatic logic [CoeffW-1:0] barrett_residue(logic [CoeffW-1:0] a,
                                                         logic [CoeffW-1:0] b);
    logic [63:0] prod, lo_x_rlo, lo_x_rhi, hi_x_rlo;
    logic [32:0] mid_word, sum_word;
    logic [31:0] prod_lo, prod_hi, carry_hi1, carry_hi2, quot_est, rem, q_word;
    prod      = 64'(a) * 64'(b);
    prod_lo   = prod[31:0];
    prod_hi   = prod[63:32];
    lo_x_rlo  = 64'(prod_lo) * 64'(cur_ratio_lo);
    lo_x_rhi  = 64'(prod_lo) * 64'(cur_ratio_hi);
    mid_word  = 33'(lo_x_rlo[63:32]) + 33'(lo_x_rhi[31:0]);
    carry_hi1 = lo_x_rhi[63:32] + 32'(mid_word[32]);
    hi_x_rlo  = 64'(prod_hi) * 64'(cur_ratio_lo);
    sum_word  = 33'(mid_word[31:0]) + 33'(hi_x_rlo[31:0]);
    carry_hi2 = hi_x_rlo[63:32] + 32'(sum_word[32]);
    quot_est  = prod_hi * cur_ratio_hi + carry_hi1 + carry_hi2;
    q_word    = 32'(cur_modulus);
    rem       = prod_lo - quot_est * q_word;
    if (rem >= q_word) begin
      rem = rem - q_word;
    end
    return rem[CoeffW-1:0];
  endfunction

  // floor(2^64 / q) truncated to 64 bits; q of zero gives all ones.
  function automatic logic [63:0] barrett_ratio(logic [CoeffW-1:0] q);
    logic [64:0] num;
    num = 65'd1 << 64;
    if (q == '0) begin
      return '1;
    end
    return 64'(num / 65'(q));
  endfunction

  // A coefficient below q, or anywhere in the field when wild is set or q is zero.
  function automatic logic [CoeffW-1:0] pick_coeff(logic [CoeffW-1:0] q, bit wild);
    if (wild || q == '0) begin
      return CoeffW'($urandom_range(CoeffMax, 0));
    end
    return CoeffW'($urandom_range(q - 1, 0));
  endfunction

  task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Present one coefficient word, with random gaps first, and wait until it is taken.
  task automatic send_word(logic [CoeffW-1:0] a, logic [CoeffW-1:0] b, logic last);
    residue_word_t exp_word;
    @(negedge clk);
    while (!no_idle && $urandom_range(99, 0) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_coeff_a = a;
    in_coeff_b = b;
    in_last_in = last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    exp_word.residue = barrett_residue(a, b);
    exp_word.last    = last;
    expected_residues.push_back(exp_word);
  endtask

  // Stop sending and wait until every result word is back and the pipe has emptied.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_residues.size() != 0) begin
      @(posedge clk);
    end
    repeat (NumStg + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      CFG_MODULUS:    cur_modulus  = data[CoeffW-1:0];
      CFG_RATIO_LOW:  cur_ratio_lo = data;
      CFG_RATIO_HIGH: cur_ratio_hi = data;
      default: ;
    endcase
  endtask

  // Load all three registers once the block has gone idle.
  task automatic load_config(logic [WordW-1:0] q_word, logic [WordW-1:0] lo,
                             logic [WordW-1:0] hi);
    wait_idle();
    write_reg(CFG_MODULUS, q_word);
    write_reg(CFG_RATIO_LOW, lo);
    write_reg(CFG_RATIO_HIGH, hi);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Load modulus q with its matching ratio; the two spare data bits are random.
  task automatic load_modulus(logic [CoeffW-1:0] q);
    logic [63:0] ratio;
    ratio = barrett_ratio(q);
    load_config({2'($urandom_range(3, 0)), q}, ratio[31:0], ratio[63:32]);
  endtask

  task automatic test_reset_config();
    send_word('0, '0, 1'b0);
    send_word(30'd1, 30'd1, 1'b1);
    send_word(30'd1, CoeffMax, 1'b0);
    send_word(CoeffMax, CoeffMax, 1'b1);
  endtask

  // Largest modulus, coefficient extremes, and operands equal to q.
  task automatic test_extreme_modulus();
    load_modulus(CoeffMax);
    send_word(CoeffW'(CoeffMax - 1), CoeffW'(CoeffMax - 1), 1'b1);
    send_word('0, CoeffW'(CoeffMax - 1), 1'b0);
    send_word(30'd1, CoeffW'(CoeffMax - 1), 1'b0);
    send_word(CoeffW'(CoeffMax - 1), 30'd1, 1'b1);
    send_word(CoeffMax, CoeffMax, 1'b1);
    send_word(CoeffMax, '0, 1'b0);
    load_modulus(30'd3);
    send_word(30'd2, 30'd2, 1'b0);
    send_word(CoeffMax, 30'd2, 1'b1);
    send_word('0, 30'd2, 1'b1);
  endtask

  // Several random moduli, each with a short polynomial of mostly in-range coefficients.
  task automatic test_random_moduli(int unsigned n_moduli, int unsigned n_words);
    logic [CoeffW-1:0] q;
    bit                wild;
    for (int unsigned i = 0; i < n_moduli; i++) begin
      case ($urandom_range(2, 0))
        0:       q = CoeffW'($urandom_range(1000, 2));
        1:       q = CoeffW'($urandom_range(CoeffMax, 2));
        default: q = CoeffW'($urandom_range(CoeffMax, CoeffMax - 4095));
      endcase
      load_modulus(q);
      for (int unsigned j = 0; j < n_words; j++) begin
        wild = ($urandom_range(9, 0) == 0);
        send_word(pick_coeff(q, wild), pick_coeff(q, wild), j == n_words - 1);
      end
    end
  endtask

  // One long polynomial with neither side idling.
  task automatic test_steady_stream();
    logic [CoeffW-1:0] q;
    q = CoeffW'($urandom_range(CoeffMax, 2));
    load_modulus(q);
    no_idle = 1'b1;
    for (int unsigned j = 0; j < 200; j++) begin
      send_word(pick_coeff(q, 1'b0), pick_coeff(q, 1'b0), 1'($urandom_range(1, 0)));
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  // Ratio words that do not belong to the modulus.
  task automatic test_mismatched_ratios();
    for (int unsigned i = 0; i < 4; i++) begin
      load_config($urandom, $urandom, $urandom);
      for (int unsigned j = 0; j < 30; j++) begin
        send_word(pick_coeff(cur_modulus, 1'b1), pick_coeff(cur_modulus, 1'b1),
                  1'($urandom_range(1, 0)));
      end
    end
  endtask

  // Moduli of zero and one, where no real reduction happens.
  task automatic test_tiny_moduli();
    logic [63:0] ratio;
    for (int unsigned q = 0; q < 2; q++) begin
      ratio = barrett_ratio(CoeffW'(q));
      load_config(WordW'(q), ratio[31:0], ratio[63:32]);
      for (int unsigned j = 0; j < 30; j++) begin
        send_word(pick_coeff('0, 1'b1), pick_coeff('0, 1'b1), 1'($urandom_range(1, 0)));
      end
    end
  endtask

  // A write to the spare index must leave every register as it was.
  task automatic test_unused_index();
    logic [CoeffW-1:0] q;
    q = CoeffW'($urandom_range(CoeffMax, 2));
    load_modulus(q);
    write_reg(CfgUnused, $urandom);
    write_reg(CfgUnused, ~cfg_wdata);
    @(negedge clk);
    cfg_we = 1'b0;
    for (int unsigned j = 0; j < 30; j++) begin
      send_word(pick_coeff(q, 1'b0), pick_coeff(q, 1'b0), 1'($urandom_range(1, 0)));
    end
  endtask

  // Result side: random stall bursts, none started while no_idle is set.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (!no_idle && $urandom_range(99, 0) < 2) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(6, 0);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each accepted result word with the oldest expected one.
  always @(posedge clk) begin
    residue_word_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_residues.size() == 0) begin
        log_mismatch("unexpected result word", 32'd0, 32'(out_residue));
      end else begin
        exp_word = expected_residues.pop_front();
        if (out_residue !== exp_word.residue) begin
          log_mismatch("residue", 32'(exp_word.residue), 32'(out_residue));
        end
        if (out_last_out !== exp_word.last) begin
          log_mismatch("last_out", 32'(exp_word.last), 32'(out_last_out));
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_config();
    test_extreme_modulus();
    test_random_moduli(24, 30);
    test_steady_stream();
    test_mismatched_ratios();
    test_tiny_moduli();
    test_unused_index();
    wait_idle();
    if (mismatch_count == 0 && expected_residues.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on run time in case the block hangs.
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
